@@ rtl/ppt_pkg.sv @@
// Package of the polyphonic pulse tone generator: types, constants, period table builder.
package ppt_pkg;

   localparam int unsigned DEFAULT_VOICES      = 8;
   localparam int unsigned DEFAULT_SAMPLE_RATE = 50000;
   localparam int unsigned TICK_SHIFT          = 2;

   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned KEY_W       = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned VOICES_ON_W = 4;

   localparam logic [COUNT_W-1:0] TICK_MASK = COUNT_W'((64'd1 << TICK_SHIFT) - 64'd1);

   localparam int unsigned BASE_FREQ = 440;
   localparam int unsigned BASE_KEY  = 69;
   localparam int unsigned SEMIS     = 12;
   localparam int unsigned KEYS      = 256;

   typedef struct packed {
      logic               note_present;
      logic [COUNT_W-1:0] note_start;
      logic [KEY_W-1:0]   note_key;
      logic [LEN_W-1:0]   note_length;
      logic               note_is_last;
   } ppt_req_type;

   typedef struct packed {
      logic [VOICES_ON_W-1:0] voices_on;
      logic                   note_taken;
      logic                   song_finished;
   } ppt_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  remaining;
      logic [PERIOD_W-1:0] period;
   } voice_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_CMP,
      ST_UPD,
      ST_LOAD,
      ST_FINISH
   } ppt_state_type;

   typedef logic [PERIOD_W-1:0] period_table_type [KEYS];

   // Powers of the twelfth root of two in unsigned Q16, rounded to nearest.
   function automatic logic [16:0] semitone_q16(input int unsigned r);
      logic [16:0] v;
      case (r)
         0:       v = 17'd65536;
         1:       v = 17'd69433;
         2:       v = 17'd73562;
         3:       v = 17'd77936;
         4:       v = 17'd82570;
         5:       v = 17'd87480;
         6:       v = 17'd92682;
         7:       v = 17'd98193;
         8:       v = 17'd104032;
         9:       v = 17'd110218;
         10:      v = 17'd116772;
         11:      v = 17'd123715;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

   // Tone periods in samples for every key, clamped to 1..65535.
   function automatic period_table_type build_period_table(input int unsigned sample_rate);
      period_table_type t;
      longint unsigned  num;
      longint unsigned  p;
      int unsigned      m;
      int unsigned      sh;
      for (int k = 0; k < KEYS; k++) begin
         m   = BASE_KEY + 16 * SEMIS - k;
         sh  = 32 - m / SEMIS;
         num = longint'(sample_rate) * longint'(semitone_q16(m % SEMIS));
         p   = (num / BASE_FREQ) >> sh;
         if (p < 1) p = 1;
         if (p > 65535) p = 65535;
         t[k] = p[PERIOD_W-1:0];
      end
      return t;
   endfunction

endpackage

@@ rtl/ppt_ifs.sv @@
// Valid/ready channel interfaces for the tone generator's input and result streams.
interface ppt_req_if;
   import ppt_pkg::*;
   logic        valid;
   logic        ready;
   ppt_req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface ppt_rsp_if;
   import ppt_pkg::*;
   logic        valid;
   logic        ready;
   ppt_rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/ppt_modulo.sv @@
// Iterative unit that computes a 32-bit count modulo a 16-bit period, four bits per cycle.
module ppt_modulo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppt_pkg::COUNT_W-1:0]  dividend,
   input  logic [ppt_pkg::PERIOD_W-1:0] divisor,
   output logic                         done,
   output logic [ppt_pkg::PERIOD_W-1:0] remainder
);
   import ppt_pkg::*;

   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned STEPS         = COUNT_W / BITS_PER_STEP;
   localparam int unsigned STEP_W        = $clog2(STEPS);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic [COUNT_W-1:0]  dvd_ff,   dvd_in;
   logic [PERIOD_W-1:0] rem_ff,   rem_in;
   logic [PERIOD_W-1:0] div_ff,   div_in;
   logic [PERIOD_W-1:0] rem_next;

   // One restoring step: the partial remainder stays below the divisor.
   function automatic logic [PERIOD_W-1:0] rem_step(input logic [PERIOD_W-1:0] r,
                                                    input logic                b,
                                                    input logic [PERIOD_W-1:0] d);
      logic [PERIOD_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[PERIOD_W-1:0];
   endfunction

   always_comb begin
      rem_next = rem_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         rem_next = rem_step(rem_next, dvd_ff[COUNT_W-1-b], div_ff);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         dvd_in  = dvd_ff << BITS_PER_STEP;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/polyphonic_pulse_tone_generator.sv @@
// Top level of the polyphonic pulse tone generator: voice memory, sweep sequencer, note loading.
//
// Every transaction on req_channel is one sample tick, optionally offering the next song note.
// Every tick yields exactly one transaction on rsp_channel: the number of voices in their on
// phase, whether the offered note was loaded, and whether the song has finished.
//
// The voice state (remaining length and period of each voice) sits in a synchronous memory of
// VOICES entries. Until the song ends, each tick reads every entry in turn, tests the phase
// of an active voice with an iterative modulo unit that retires four dividend bits per cycle,
// writes the decremented length back, and finally loads the note into the lowest free voice.
//
// After acceptance the sequencer passes READ and EVAL for each voice; an active voice with a
// nonzero period and voice count then waits in DIV for the modulo unit and passes CMP, and every
// active voice passes UPD. LOAD and FINISH follow the last voice; FINISH loads the result
// register when it is free. Once the song has finished, an accepted tick goes straight to FINISH.
// One tick at a time.
//
// Synchronous reset clears the voices (through per-entry valid bits), the sample counter, the
// active count and the finished flag. The result register holds its transaction while the
// receiver stalls; the next tick may be accepted meanwhile and waits for the register to free.
module polyphonic_pulse_tone_generator #(
   parameter int unsigned VOICES      = ppt_pkg::DEFAULT_VOICES,
   parameter int unsigned SAMPLE_RATE = ppt_pkg::DEFAULT_SAMPLE_RATE
) (
   input logic     clock,
   input logic     reset,
   ppt_req_if.sink   req_channel,
   ppt_rsp_if.source rsp_channel
);
   import ppt_pkg::*;

   localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int unsigned CNT_W  = $clog2(VOICES + 1);
   localparam int unsigned MUL_W  = PERIOD_W + 1 + CNT_W;

   localparam period_table_type PERIOD_TABLE = build_period_table(SAMPLE_RATE);

   ppt_state_type state_ff, state_in;

   // Tick bookkeeping.
   logic [COUNT_W-1:0]  sample_count_ff, sample_count_in;
   logic [CNT_W-1:0]    active_ff,       active_in;
   logic                done_ff,         done_in;
   logic [VOICES-1:0]   valid_ff,        valid_in;

   // Per-tick working registers.
   ppt_req_type         req_ff,          req_in;
   logic [PERIOD_W-1:0] period_ff,       period_in;
   logic [CNT_W-1:0]    n_ff,            n_in;
   logic [VIDX_W-1:0]   idx_ff,          idx_in;
   logic                free_found_ff,   free_found_in;
   logic [VIDX_W-1:0]   free_idx_ff,     free_idx_in;
   logic [CNT_W-1:0]    on_ff,           on_in;
   logic                taken_ff,        taken_in;
   voice_entry_type     cur_ff,          cur_in;

   // Result register.
   logic                out_valid_ff,    out_valid_in;
   ppt_rsp_type         out_ff,          out_in;

   // Voice memory and its ports.
   voice_entry_type     voice_mem [VOICES];
   voice_entry_type     rd_data_ff;
   logic                rd_valid_ff;
   logic                mem_rd_en;
   logic                mem_wr_en;
   logic [VIDX_W-1:0]   mem_wr_addr;
   voice_entry_type     mem_wr_data;

   logic                mod_start;
   logic                mod_done;
   logic [PERIOD_W-1:0] mod_rem;

   voice_entry_type     rd_entry;
   logic                last_voice;
   logic                load_ok;
   logic [MUL_W-1:0]    on_prod;

   ppt_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (sample_count_ff),
      .divisor   (rd_entry.period),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // A never-written entry reads as a free voice with zero period.
   assign rd_entry   = rd_valid_ff ? rd_data_ff : '0;
   assign last_voice = (idx_ff == VIDX_W'(VOICES - 1));

   // Notes are checked only on note-tick boundaries, once their start time has come.
   assign load_ok = ((sample_count_ff & TICK_MASK) == '0) && req_ff.note_present &&
                    (req_ff.note_start <= (sample_count_ff >> TICK_SHIFT));

   // phase < (period/2)/n is the same test as (phase+1)*n <= period/2.
   assign on_prod = (MUL_W'(mod_rem) + MUL_W'(1)) * MUL_W'(n_ff);

   assign req_channel.ready   = (state_ff == ST_IDLE);
   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_ff;

   always_comb begin
      state_in        = state_ff;
      sample_count_in = sample_count_ff;
      active_in       = active_ff;
      done_in         = done_ff;
      valid_in        = valid_ff;
      req_in          = req_ff;
      period_in       = period_ff;
      n_in            = n_ff;
      idx_in          = idx_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      on_in           = on_ff;
      taken_in        = taken_ff;
      cur_in          = cur_ff;
      out_valid_in    = out_valid_ff && !rsp_channel.ready;
      out_in          = out_ff;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = idx_ff;
      mem_wr_data     = '0;
      mod_start       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_channel.valid) begin
               req_in        = req_channel.payload;
               period_in     = PERIOD_TABLE[req_channel.payload.note_key];
               n_in          = active_ff;
               idx_in        = '0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               on_in         = '0;
               taken_in      = 1'b0;
               // A finished song goes straight to the answer and leaves the state alone.
               state_in      = done_ff ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            cur_in = rd_entry;
            if (rd_entry.remaining == '0) begin
               if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (last_voice) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + VIDX_W'(1);
                  state_in = ST_READ;
               end
            end else if (rd_entry.period != '0 && n_ff != '0) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (on_prod <= MUL_W'(cur_ff.period >> 1)) begin
               on_in = on_ff + CNT_W'(1);
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            mem_wr_en             = 1'b1;
            mem_wr_addr           = idx_ff;
            mem_wr_data.remaining = cur_ff.remaining - COUNT_W'(1);
            mem_wr_data.period    = cur_ff.period;
            valid_in[idx_ff]      = 1'b1;
            // The voice runs out on this tick and becomes free for the note check.
            if (cur_ff.remaining == COUNT_W'(1)) begin
               if (active_ff != '0) begin
                  active_in = active_ff - CNT_W'(1);
               end
               if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
            end
            if (last_voice) begin
               state_in = ST_LOAD;
            end else begin
               idx_in   = idx_ff + VIDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_LOAD: begin
            if (load_ok) begin
               if (req_ff.note_length == '0) begin
                  // A zero-length note is taken without occupying a voice.
                  taken_in = 1'b1;
                  done_in  = done_ff || req_ff.note_is_last;
               end else if (free_found_ff) begin
                  mem_wr_en             = 1'b1;
                  mem_wr_addr           = free_idx_ff;
                  mem_wr_data.remaining = COUNT_W'(req_ff.note_length) << TICK_SHIFT;
                  mem_wr_data.period    = period_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  active_in             = active_ff + CNT_W'(1);
                  taken_in              = 1'b1;
                  done_in               = done_ff || req_ff.note_is_last;
               end
            end
            sample_count_in = sample_count_ff + COUNT_W'(1);
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_channel.ready) begin
               out_valid_in         = 1'b1;
               out_in.voices_on     = VOICES_ON_W'(on_ff);
               out_in.note_taken    = taken_ff;
               out_in.song_finished = done_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_count_ff <= '0;
         active_ff       <= '0;
         done_ff         <= 1'b0;
         valid_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sample_count_ff <= sample_count_in;
         active_ff       <= active_in;
         done_ff         <= done_in;
         valid_ff        <= valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      period_ff     <= period_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      on_ff         <= on_in;
      taken_ff      <= taken_in;
      cur_ff        <= cur_in;
      out_ff        <= out_in;
   end

   // Voice memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         voice_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff  <= voice_mem[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
      end
   end

endmodule

@@ rtl/ppt_checker.sv @@
// Port-level checker of the tone generator, bound to the top level.
module ppt_checker #(
   parameter int unsigned VOICES = ppt_pkg::DEFAULT_VOICES
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ppt_pkg::VOICES_ON_W-1:0] rsp_voices_on,
   input logic                            rsp_note_taken,
   input logic                            rsp_song_finished
);
   import ppt_pkg::*;

   logic       req_accept;
   logic       rsp_accept;
   logic [2:0] pending_ff, pending_in;
   logic       finished_ff, finished_in;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_accept && !rsp_accept && pending_ff != 3'd7) pending_in = pending_ff + 3'd1;
      if (!req_accept && rsp_accept && pending_ff != 3'd0) pending_in = pending_ff - 3'd1;
      finished_in = finished_ff || (rsp_accept && rsp_song_finished);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         finished_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         finished_ff <= finished_in;
      end
   end

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_voices_on, rsp_note_taken, rsp_song_finished}))
      else $error("result changed while stalled");

   // Every result transaction answers an accepted tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept |-> pending_ff != 3'd0)
      else $error("result without an accepted tick");

   // Once the song has finished, every later tick is silent and reports it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && finished_ff |-> rsp_song_finished && !rsp_note_taken &&
         rsp_voices_on == '0)
      else $error("activity after the song finished");

   // The on count cannot exceed the number of voices.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (VOICES >= 16) || (rsp_voices_on <= VOICES_ON_W'(VOICES)))
      else $error("more voices on than exist");

endmodule

bind polyphonic_pulse_tone_generator ppt_checker #(.VOICES(VOICES)) u_ppt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_channel.valid),
   .req_ready         (req_channel.ready),
   .rsp_valid         (rsp_channel.valid),
   .rsp_ready         (rsp_channel.ready),
   .rsp_voices_on     (rsp_channel.payload.voices_on),
   .rsp_note_taken    (rsp_channel.payload.note_taken),
   .rsp_song_finished (rsp_channel.payload.song_finished)
);
